// ===== sv/bmhq_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the heap queue.
package bmhq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Fixed widths of the channel fields.
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  // Entry count and heap slot numbers (slots run 1..CAPACITY).
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Read address selects for the heap memory.
  localparam logic [2:0] RD_ROOT   = 3'd0;
  localparam logic [2:0] RD_LAST   = 3'd1;
  localparam logic [2:0] RD_PARENT = 3'd2;
  localparam logic [2:0] RD_LEFT   = 3'd3;
  localparam logic [2:0] RD_RIGHT  = 3'd4;

  // Write data selects for the heap memory.
  localparam logic [1:0] WR_MOV   = 2'd0;
  localparam logic [1:0] WR_RDATA = 2'd1;
  localparam logic [1:0] WR_CHILD = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       set_err;
    logic       start_ins;
    logic       start_rem;
    logic       cap_result;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_src;
    logic       pos_to_parent;
    logic       pos_to_child;
    logic       cap_left;
    logic       cap_right;
    logic       out_load;
  } bmhq_cmd_t;

  typedef struct packed {
    logic op_remove;
    logic full;
    logic empty;
    logic at_root;
    logic left_exists;
    logic right_exists;
    logic parent_less_mov;
    logic mov_less_child;
    logic out_free;
  } bmhq_stat_t;

endpackage

// ===== sv/bmhq_in_if.sv =====
// Request channel interface: operation and value to insert.
interface bmhq_in_if;
  import bmhq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [VALUE_W-1:0] value_in;

  modport source (output valid, output opcode, output value_in, input ready);
  modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

// ===== sv/bmhq_out_if.sv =====
// Result channel interface: removed value, status, count and empty flag.
interface bmhq_out_if;
  import bmhq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_OUT_W-1:0]    count_after;
  logic                      empty_after;

  modport source (output valid, output value_out, output status, output count_after,
                  output empty_after, input ready);
  modport sink   (input valid, input value_out, input status, input count_after,
                  input empty_after, output ready);
endinterface

// ===== sv/bmhq_datapath.sv =====
// Heap datapath: heap memory, entry count, sift registers, comparators and result register.
module bmhq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              opcode,
  input  logic signed [bmhq_pkg::VALUE_W-1:0] value_in,
  input  bmhq_pkg::bmhq_cmd_t               cmd,
  output bmhq_pkg::bmhq_stat_t              stat,
  bmhq_out_if.source                        rsp
);
  import bmhq_pkg::*;

  word_t mem [CAPACITY];
  word_t rdata;

  cnt_t  count;
  cnt_t  pos;
  cnt_t  child_pos;
  word_t mov;
  word_t child_val;
  word_t result;
  word_t value_q;
  logic  op_q;
  logic [STATUS_W-1:0] status_q;
  logic  out_valid;

  logic [CNT_W:0]    left_slot;
  logic [CNT_W:0]    right_slot;
  logic [CNT_W:0]    rd_slot;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  word_t             wr_data;

  assign left_slot  = {pos, 1'b0};
  assign right_slot = {pos, 1'b1};

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   rd_slot = (CNT_W+1)'(1);
      RD_LAST:   rd_slot = {1'b0, count};
      RD_PARENT: rd_slot = {2'b00, pos[CNT_W-1:1]};
      RD_LEFT:   rd_slot = left_slot;
      RD_RIGHT:  rd_slot = right_slot;
      default:   rd_slot = (CNT_W+1)'(1);
    endcase
  end

  assign rd_addr = ADDR_W'(rd_slot - (CNT_W+1)'(1));
  assign wr_addr = ADDR_W'(pos - CNT_W'(1));

  always_comb begin
    case (cmd.wr_src)
      WR_RDATA: wr_data = rdata;
      WR_CHILD: wr_data = child_val;
      default:  wr_data = mov;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start_ins) begin
        count <= count + CNT_W'(1);
      end else if (cmd.start_rem) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= opcode;
      value_q  <= DATA_WIDTH'(value_in);
      result   <= '0;
      status_q <= ST_OK;
    end
    if (cmd.set_err) begin
      status_q <= (op_q == OP_REMOVE) ? ST_EMPTY : ST_FULL;
    end
    if (cmd.start_ins) begin
      pos <= count + CNT_W'(1);
      mov <= value_q;
    end
    if (cmd.cap_result) begin
      result <= rdata;
    end
    if (cmd.start_rem) begin
      pos <= CNT_W'(1);
      mov <= rdata;
    end
    if (cmd.pos_to_parent) begin
      pos <= {1'b0, pos[CNT_W-1:1]};
    end
    if (cmd.pos_to_child) begin
      pos <= child_pos;
    end
    if (cmd.cap_left) begin
      child_val <= rdata;
      child_pos <= CNT_W'(left_slot);
    end
    // Ties keep the left child.
    if (cmd.cap_right && (child_val < rdata)) begin
      child_val <= rdata;
      child_pos <= CNT_W'(right_slot);
    end
    if (cmd.out_load) begin
      rsp.value_out   <= VALUE_W'(result);
      rsp.status      <= status_q;
      rsp.count_after <= COUNT_OUT_W'(count);
      rsp.empty_after <= (count == '0);
    end
  end

  assign rsp.valid = out_valid;

  assign stat.op_remove       = (op_q == OP_REMOVE);
  assign stat.full            = (count >= CNT_W'(CAPACITY));
  assign stat.empty           = (count == '0);
  assign stat.at_root         = (pos == CNT_W'(1));
  assign stat.left_exists     = (left_slot <= {1'b0, count});
  assign stat.right_exists    = (left_slot < {1'b0, count});
  assign stat.parent_less_mov = (rdata < mov);
  assign stat.mov_less_child  = (mov < child_val);
  assign stat.out_free        = !out_valid || rsp.ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
    (count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || rsp.ready))
    else $error("result register overwritten before transfer");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (pos != '0) && (pos <= count))
    else $error("heap write outside held entries");

endmodule

// ===== sv/bmhq_ctrl.sv =====
// Heap controller: sequences insert sift-up and remove sift-down over the datapath.
module bmhq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  bmhq_pkg::bmhq_stat_t stat,
  output bmhq_pkg::bmhq_cmd_t  cmd
);
  import bmhq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_REM_LAST = 4'd2;
  localparam logic [3:0] S_REM_MOV  = 4'd3;
  localparam logic [3:0] S_UP_CHK   = 4'd4;
  localparam logic [3:0] S_UP_CMP   = 4'd5;
  localparam logic [3:0] S_DN_CHK   = 4'd6;
  localparam logic [3:0] S_DN_RL    = 4'd7;
  localparam logic [3:0] S_DN_RR    = 4'd8;
  localparam logic [3:0] S_DN_CMP   = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_ROOT;
    cmd.wr_src = WR_MOV;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op_remove ? stat.empty : stat.full) begin
          cmd.set_err = 1'b1;
          state_next  = S_FIN;
        end else if (stat.op_remove) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ROOT;
          state_next = S_REM_LAST;
        end else begin
          cmd.start_ins = 1'b1;
          state_next    = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (stat.at_root) begin
          cmd.wr_en  = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.parent_less_mov) begin
          cmd.wr_src        = WR_RDATA;
          cmd.pos_to_parent = 1'b1;
          state_next        = S_UP_CHK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_REM_LAST: begin
        cmd.cap_result = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_LAST;
        state_next     = S_REM_MOV;
      end
      S_REM_MOV: begin
        cmd.start_rem = 1'b1;
        state_next    = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (!stat.left_exists) begin
          // When the only entry was removed there is nothing left to place.
          cmd.wr_en  = !stat.empty;
          state_next = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_RL;
        end
      end
      S_DN_RL: begin
        cmd.cap_left = 1'b1;
        if (stat.right_exists) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RIGHT;
          state_next = S_DN_RR;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_RR: begin
        cmd.cap_right = 1'b1;
        state_next    = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.mov_less_child) begin
          cmd.wr_src       = WR_CHILD;
          cmd.pos_to_child = 1'b1;
          state_next       = S_DN_CHK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid) |=> (state == S_DECIDE))
    else $error("accepted request did not start decoding");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.set_err, cmd.start_ins, cmd.start_rem, cmd.out_load}))
    else $error("conflicting controller commands");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !stat.out_free) |=> (state == S_FIN))
    else $error("finished request left while the result register was busy");

endmodule

// ===== sv/binary_max_heap_queue.sv =====
// Max priority queue kept as a binary heap: top level joining controller and datapath.
//
// Usage: the req channel carries one operation per transfer: opcode insert with a
// signed value_in, or opcode remove, which ignores value_in. For every request the
// rsp channel returns exactly one transfer with value_out (the removed maximum on a
// successful remove, otherwise zero), status (ok, remove on empty, insert on full),
// count_after and empty_after. A refused operation leaves the heap untouched.
// Requests are handled one at a time; req.ready is high only while the controller
// is idle, so the block takes no new request before the last one's result is
// loaded. A refused operation is flagged when the request is decoded. An insert
// places the new value in the next free slot and, while the parent is smaller,
// reads the parent and moves it down; it stops below a parent that is not smaller.
// A remove reads the root and the last entry, moves the last entry to the root and
// sinks it: at each node with children it reads the left and, if present, the
// right child and moves the larger child up while the moving value is smaller.
// The finished result waits in an output register, so the next request is
// taken while the receiver stalls; a request finishing before that register frees
// waits in its final state. Synchronous reset empties the heap at once (count to
// zero), holds req.ready low and drops any pending result; heap memory contents are
// never cleared.
module binary_max_heap_queue (
  input logic        clk,
  input logic        rst,
  bmhq_in_if.sink    req,
  bmhq_out_if.source rsp
);
  import bmhq_pkg::*;

  bmhq_cmd_t  cmd;
  bmhq_stat_t stat;
  logic       ready;

  // The controller owns the request handshake; the datapath owns the result register.
  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  assign req.ready = ready;

  bmhq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .opcode   (req.opcode),
    .value_in (req.value_in),
    .cmd      (cmd),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the binary max heap priority queue.
module tb;
  import bmhq_pkg::*;

  typedef logic signed [VALUE_W-1:0] value_t;

  // One response transfer, as the checker compares it.
  typedef struct {
    value_t                 value_out;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count_after;
    logic                   empty_after;
  } heap_result_t;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 526;
  localparam int IDLE_PCT     = 13;
  // Requests with these sequence numbers go out back to back, and the
  // response side never stalls while it collects the matching results.
  localparam int CALM_FROM    = 60;
  localparam int CALM_TO      = 160;
  // Once this many requests are in, the response side holds off for a long
  // while so that the output register fills and req.ready drops.
  localparam int HOLD_AT      = 280;
  localparam int HOLD_CYCLES  = 150;
  // Longer than the slowest request takes, so this settles any stray work.
  localparam int DRAIN_CYCLES = 40;

  localparam value_t V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // The tracker keeps its own copy of the heap. Each accepted request is
  // applied to it at once and the result it must produce is queued; results
  // come back in request order, so the oldest queued one is the match.
  class heap_tracker;
    word_t        slots [1:CAPACITY];
    int           entries;
    heap_result_t pending_results [$];
    int           errors;
    int           n_insert;
    int           n_remove;
    int           n_empty_remove;
    int           n_full_insert;

    function new();
      entries        = 0;
      errors         = 0;
      n_insert       = 0;
      n_remove       = 0;
      n_empty_remove = 0;
      n_full_insert  = 0;
    endfunction

    function void swap_slots(int a, int b);
      word_t tmp;
      tmp      = slots[a];
      slots[a] = slots[b];
      slots[b] = tmp;
    endfunction

    function void note_request(logic op, value_t v);
      heap_result_t r;
      int           pos;
      int           child;
      r.value_out = '0;
      r.status    = ST_OK;
      if (op == OP_INSERT) begin
        if (entries >= CAPACITY) begin
          r.status = ST_FULL;
          n_full_insert++;
        end else begin
          // Append, then climb while the parent is strictly smaller; a value
          // stops below an equal parent.
          entries++;
          slots[entries] = word_t'(v);
          pos = entries;
          while (pos > 1 && slots[pos / 2] < slots[pos]) begin
            swap_slots(pos, pos / 2);
            pos = pos / 2;
          end
          n_insert++;
        end
      end else if (entries == 0) begin
        r.status = ST_EMPTY;
        n_empty_remove++;
      end else begin
        // Take the root, move the last entry up and sink it toward the larger
        // child. On a tie between children the left one wins, and the walk
        // ends when the chosen child merely equals the moving entry.
        r.value_out = value_t'(slots[1]);
        slots[1] = slots[entries];
        entries--;
        pos = 1;
        while (2 * pos <= entries) begin
          child = 2 * pos;
          if (child < entries && slots[child] < slots[child + 1])
            child++;
          if (!(slots[pos] < slots[child]))
            break;
          swap_slots(pos, child);
          pos = child;
        end
        n_remove++;
      end
      r.count_after = COUNT_OUT_W'(entries);
      r.empty_after = (entries == 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (pending_results.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.count_after !== want.count_after) begin
        $error("count_after: expected %0d, got %0d", want.count_after, got.count_after);
        errors++;
      end
      if (got.empty_after !== want.empty_after) begin
        $error("empty_after: expected %0d, got %0d", want.empty_after, got.empty_after);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmhq_in_if  req_ch ();
  bmhq_out_if rsp_ch ();

  binary_max_heap_queue uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  heap_tracker tracker;
  int          sent     = 0;
  int          received = 0;
  int          cycles   = 0;
  bit          hold_rsp = 1'b0;

  always #2 clk = ~clk;

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Draws a value to insert. Extremes and a narrow band around zero come up
  // often, the band so that equal keys meet in the heap; the rest is spread
  // over the whole word so that every bit takes both values.
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return V_MAX;
      1:       return V_MIN;
      2:       return $urandom_range(1) ? value_t'(0) : value_t'(-1);
      3, 4, 5: return value_t'(int'($urandom_range(16)) - 8);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Offers one request from a falling edge and returns at the falling edge
  // after its transfer. Inputs only ever change on falling edges, and each
  // signal is written at most once per edge.
  task automatic send_item(input logic op, input value_t v);
    bit calm;
    calm = (sent >= CALM_FROM && sent < CALM_TO);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.opcode   = op;
    req_ch.value_in = v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    tracker.note_request(op, v);
    sent++;
    @(negedge clk);
  endtask

  // Response side: ready is chosen on the falling edge and the transfer is
  // taken at the rising edge, where the block's registered outputs still
  // hold their values from before the edge.
  initial begin
    heap_result_t got;
    bit           calm;
    rsp_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      calm = (received >= CALM_FROM && received < CALM_TO);
      rsp_ch.ready = !hold_rsp && (calm || $urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
        got.value_out   = rsp_ch.value_out;
        got.status      = rsp_ch.status;
        got.count_after = rsp_ch.count_after;
        got.empty_after = rsp_ch.empty_after;
        tracker.check_result(got);
        received++;
      end
      @(negedge clk);
    end
  end

  // The long hold-off, timed in cycles here while the sender keeps offering.
  initial begin
    wait (sent >= HOLD_AT);
    @(negedge clk);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_rsp = 1'b0;
  end

  initial begin
    int   target;
    int   burst;
    int   ins_pct;
    logic op;

    tracker         = new();
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_INSERT;
    req_ch.value_in = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: a remove on the empty heap, both extremes, zero and
    // minus one, a run of equal keys, removes across them, then filling the
    // heap to capacity and one insert that must be refused as full.
    send_item(OP_REMOVE, V_MAX);
    send_item(OP_INSERT, V_MIN);
    send_item(OP_INSERT, V_MAX);
    send_item(OP_INSERT, value_t'(0));
    send_item(OP_INSERT, value_t'(-1));
    send_item(OP_INSERT, value_t'(5));
    send_item(OP_INSERT, value_t'(5));
    send_item(OP_INSERT, value_t'(5));
    repeat (3) send_item(OP_REMOVE, value_t'($urandom));
    for (int i = 0; i < 12; i++) begin
      case (i % 3)
        0:       send_item(OP_INSERT, value_t'(32'h5555_5555));
        1:       send_item(OP_INSERT, value_t'(32'hAAAA_AAAA));
        default: send_item(OP_INSERT, value_t'(-i));
      endcase
    end
    send_item(OP_INSERT, V_MAX);

    // Random part in bursts that lean toward filling, toward draining, or
    // neither, so the heap keeps running into both its full and empty ends.
    // Removes carry random values that the block has to ignore.
    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      burst = $urandom_range(60, 15);
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      repeat (burst) begin
        if (sent < target) begin
          op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
          send_item(op, (op == OP_INSERT) ? pick_value() : value_t'($urandom));
        end
      end
    end
    req_ch.valid = 1'b0;

    // Wait for every outstanding result, then a little longer so that any
    // extra transfer from the block would still be caught.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.errors += tracker.pending_results.size();

    $display("summary: %0d requests and %0d results; %0d inserts, %0d removes,",
             sent, received, tracker.n_insert, tracker.n_remove);
    $display("summary: %0d removes on an empty heap, %0d inserts on a full heap",
             tracker.n_empty_remove, tracker.n_full_insert);
    if (tracker.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
